/* src/collatz_length_memo_defines.svh */
// ---------------------------------------------------------------------------
// collatz_length_memo_defines.svh
// Assertion macros shared by the Collatz length block.
// ---------------------------------------------------------------------------
`ifndef COLLATZ_LENGTH_MEMO_DEFINES_SVH
`define COLLATZ_LENGTH_MEMO_DEFINES_SVH

`ifndef NO_ASSERTIONS

// The consequent must hold in the same cycle as the antecedent.
`define CLM_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("collatz_length_memo: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define CLM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("collatz_length_memo: next-cycle check failed");

`else

`define CLM_ASSERT_SAME(label, clk, rst, ante, cons)
`define CLM_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

/* src/clm_pkg.sv */
// ---------------------------------------------------------------------------
// clm_pkg
// Widths and constants of the Collatz length block.
// ---------------------------------------------------------------------------
package clm_pkg;

   localparam int VALUE_W          = 64;
   localparam int LEN_W            = 16;
   localparam int COUNT_W          = LEN_W + 1;
   localparam int MEMO_ENTRIES_DEF = 65536;

   localparam logic [LEN_W-1:0]   LEN_MAX   = '1;
   // Largest value whose 3v+1 still fits in 64 bits.
   localparam logic [VALUE_W-1:0] ODD_LIMIT = 64'd6148914691236517204;

endpackage

/* src/clm_ram.sv */
// ---------------------------------------------------------------------------
// clm_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ---------------------------------------------------------------------------
module clm_ram #(
   parameter int WIDTH  = clm_pkg::LEN_W,
   parameter int DEPTH  = clm_pkg::MEMO_ENTRIES_DEF,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/collatz_length_memo.sv */
// After reset the length store is cleared, one entry a cycle, over all MEMO_ENTRIES
// entries; no request beat is taken during that pass.
// Per item: the start value is accepted, each step on a value at or above MEMO_ENTRIES
// is taken directly, a step inside the store first reads it (registered read data),
// the walk ends on the final 1 or on a stored length, and the result is handed over.
// One item is walked at a time; the next may be taken while a result waits.
// ---------------------------------------------------------------------------
// collatz_length_memo
// Collatz sequence length of a 64-bit start value, with a store of known
// lengths that cuts the walk short and is written back on success.
// ---------------------------------------------------------------------------
`include "collatz_length_memo_defines.svh"

module collatz_length_memo #(
   parameter int MEMO_ENTRIES = clm_pkg::MEMO_ENTRIES_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   // req_tdata: start_value [63:0]
   input  logic [clm_pkg::VALUE_W-1:0] req_tdata,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // rsp_tdata: seq_length [15:0]
   output logic [clm_pkg::LEN_W-1:0]   rsp_tdata,
   // rsp_tuser: error_flag [0]
   output logic                        rsp_tuser,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready
);

   localparam int ADDR_W  = (MEMO_ENTRIES > 1) ? $clog2(MEMO_ENTRIES) : 1;
   localparam int VALUE_W = clm_pkg::VALUE_W;
   localparam int LEN_W   = clm_pkg::LEN_W;
   localparam int COUNT_W = clm_pkg::COUNT_W;

   localparam logic [VALUE_W-1:0] ENTRIES_V = VALUE_W'(MEMO_ENTRIES);
   localparam logic [ADDR_W-1:0]  LAST_ADDR = ADDR_W'(MEMO_ENTRIES - 1);

   typedef enum logic [4:0] {
      ST_CLEAR = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_WALK  = 5'b00100,
      ST_CHECK = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

   state_type           state_ff, state_in;
   logic [ADDR_W-1:0]   clr_addr_ff, clr_addr_in;
   logic [VALUE_W-1:0]  value_ff, value_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic [ADDR_W-1:0]   start_addr_ff, start_addr_in;
   logic                in_store_ff, in_store_in;
   logic [LEN_W-1:0]    res_len_ff, res_len_in;
   logic                res_err_ff, res_err_in;
   logic                rsp_tvalid_ff, rsp_tvalid_in;
   logic [LEN_W-1:0]    rsp_len_ff, rsp_len_in;
   logic                rsp_err_ff, rsp_err_in;

   logic                mem_wr_en;
   logic [ADDR_W-1:0]   mem_wr_addr;
   logic [LEN_W-1:0]    mem_wr_data;
   logic                mem_rd_en;
   logic [LEN_W-1:0]    mem_rd_data;

   logic                out_free;
   logic                req_beat;
   logic                value_in_store;
   logic [VALUE_W-1:0]  step_value;
   logic [COUNT_W-1:0]  count_inc;
   logic [COUNT_W-1:0]  memo_sum;

   clm_ram #(
      .WIDTH  (LEN_W),
      .DEPTH  (MEMO_ENTRIES),
      .ADDR_W (ADDR_W)
   ) u_memo (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (value_ff[ADDR_W-1:0]),
      .rd_data (mem_rd_data)
   );

   assign out_free       = !rsp_tvalid_ff || rsp_tready;
   assign req_tready     = (state_ff == ST_IDLE);
   assign req_beat       = req_tvalid && req_tready;
   assign value_in_store = (value_ff < ENTRIES_V);
   assign count_inc      = count_ff + COUNT_W'(1);
   assign memo_sum       = count_ff + {1'b0, mem_rd_data} - COUNT_W'(1);
   // 3v+1 for odd values, a halving otherwise; the odd case is only taken
   // after the overflow limit has been checked.
   assign step_value     = value_ff[0] ? ((value_ff << 1) + value_ff + VALUE_W'(1))
                                       : (value_ff >> 1);

   assign mem_rd_en = (state_ff == ST_WALK) && (value_ff != VALUE_W'(1)) && value_in_store;

   always_comb begin
      mem_wr_en   = 1'b0;
      mem_wr_addr = clr_addr_ff;
      mem_wr_data = '0;
      if (state_ff == ST_CLEAR) begin
         mem_wr_en = 1'b1;
      end else if (state_ff == ST_DONE && out_free && in_store_ff && !res_err_ff) begin
         mem_wr_en   = 1'b1;
         mem_wr_addr = start_addr_ff;
         mem_wr_data = res_len_ff;
      end
   end

   always_comb begin
      state_in      = state_ff;
      clr_addr_in   = clr_addr_ff;
      value_in      = value_ff;
      count_in      = count_ff;
      start_addr_in = start_addr_ff;
      in_store_in   = in_store_ff;
      res_len_in    = res_len_ff;
      res_err_in    = res_err_ff;
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_len_in    = rsp_len_ff;
      rsp_err_in    = rsp_err_ff;

      if (rsp_tvalid_ff && rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end

      case (state_ff)
         ST_CLEAR: begin
            clr_addr_in = clr_addr_ff + ADDR_W'(1);
            if (clr_addr_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_beat) begin
               value_in      = req_tdata;
               count_in      = COUNT_W'(1);
               start_addr_in = req_tdata[ADDR_W-1:0];
               in_store_in   = (req_tdata < ENTRIES_V);
               if (req_tdata == '0) begin
                  res_len_in = '0;
                  res_err_in = 1'b1;
                  state_in   = ST_DONE;
               end else begin
                  state_in = ST_WALK;
               end
            end
         end
         ST_WALK, ST_CHECK: begin
            if (state_ff == ST_WALK && value_ff == VALUE_W'(1)) begin
               res_len_in = count_ff[LEN_W-1:0];
               res_err_in = 1'b0;
               state_in   = ST_DONE;
            end else if (state_ff == ST_WALK && value_in_store) begin
               state_in = ST_CHECK;
            end else if (state_ff == ST_CHECK && mem_rd_data != '0) begin
               // Known length: the shared term is counted once.
               state_in = ST_DONE;
               if (memo_sum[LEN_W]) begin
                  res_len_in = clm_pkg::LEN_MAX;
                  res_err_in = 1'b1;
               end else begin
                  res_len_in = memo_sum[LEN_W-1:0];
                  res_err_in = 1'b0;
               end
            end else if (value_ff[0] && value_ff > clm_pkg::ODD_LIMIT) begin
               res_len_in = '0;
               res_err_in = 1'b1;
               state_in   = ST_DONE;
            end else begin
               value_in = step_value;
               count_in = count_inc;
               if (count_inc[LEN_W]) begin
                  res_len_in = clm_pkg::LEN_MAX;
                  res_err_in = 1'b1;
                  state_in   = ST_DONE;
               end else begin
                  state_in = ST_WALK;
               end
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_len_in    = res_len_ff;
               rsp_err_in    = res_err_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_addr_ff   <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_addr_ff   <= clr_addr_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff      <= value_in;
      count_ff      <= count_in;
      start_addr_ff <= start_addr_in;
      in_store_ff   <= in_store_in;
      res_len_ff    <= res_len_in;
      res_err_ff    <= res_err_in;
      rsp_len_ff    <= rsp_len_in;
      rsp_err_ff    <= rsp_err_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_len_ff;
   assign rsp_tuser  = rsp_err_ff;

   // An error beat carries either zero or the saturated length.
   `CLM_ASSERT_SAME(a_err_len, clock, reset, rsp_tvalid && rsp_tuser,
                    rsp_tdata == '0 || rsp_tdata == clm_pkg::LEN_MAX)
   // A good beat always counts at least the start value itself.
   `CLM_ASSERT_SAME(a_ok_len, clock, reset, rsp_tvalid && !rsp_tuser, rsp_tdata != '0)
   // The store is written only by the clearing pass or on handing over a result.
   `CLM_ASSERT_SAME(a_wr_state, clock, reset, mem_wr_en,
                    state_ff == ST_CLEAR || state_ff == ST_DONE)
   // A zero start value goes straight to an error result.
   `CLM_ASSERT_NEXT(a_zero_in, clock, reset, req_beat && req_tdata == '0,
                    state_ff == ST_DONE && res_err_ff)
   // The running count never passes the 16-bit range while walking.
   `CLM_ASSERT_SAME(a_count_rng, clock, reset,
                    state_ff == ST_WALK || state_ff == ST_CHECK, !count_ff[LEN_W])

endmodule

/* tb/tb_collatz_length_memo.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_collatz_length_memo
// Drives start values into the Collatz length block and checks each returned
// length and error flag against a local model that keeps its own copy of the
// length store. A short table of corner values runs first, then random values
// spread over small, 32-bit, full-width and near-overflow ranges, with random
// gaps on both sides, one long result stall and a full drain midway.
// ---------------------------------------------------------------------------
module tb_collatz_length_memo;

   localparam int MEMO_ENTRIES   = clm_pkg::MEMO_ENTRIES_DEF;
   localparam int RANDOM_ITEMS   = 1600;
   localparam int QUIET_ITEMS    = 200;
   localparam int HOLD_AT_ITEM   = 400;
   localparam int DRAIN_AT_ITEM  = 900;
   localparam int LONG_HOLD      = 3000;
   localparam int TAIL_CYCLES    = 4000;
   localparam int REPORT_LIMIT   = 10;

   typedef struct packed {
      logic [clm_pkg::LEN_W-1:0] seq_length;
      logic                      error_flag;
   } len_result_type;

   typedef struct {
      logic [clm_pkg::VALUE_W-1:0] value;
      bit                          known;
      len_result_type              result;
   } start_row_type;

   logic                        clock      = 1'b0;
   logic                        reset      = 1'b1;
   logic [clm_pkg::VALUE_W-1:0] req_tdata  = '0;
   logic                        req_tvalid = 1'b0;
   logic                        req_tready;
   logic [clm_pkg::LEN_W-1:0]   rsp_tdata;
   logic                        rsp_tuser;
   logic                        rsp_tvalid;
   logic                        rsp_tready = 1'b0;

   logic [clm_pkg::LEN_W-1:0] known_lengths [0:MEMO_ENTRIES-1];
   len_result_type            pending_lengths [$];
   start_row_type             corner_starts [$];
   int unsigned               mismatch_count = 0;
   bit                        quiet_tail     = 1'b0;
   bit                        long_hold_req  = 1'b0;

   collatz_length_memo u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready)
   );

   always #5 clock = ~clock;

   // Walks the sequence with the local store, and writes the start value's
   // length back exactly where the block is expected to.
   function automatic len_result_type walk_length(input logic [clm_pkg::VALUE_W-1:0] start);
      logic [clm_pkg::VALUE_W-1:0] v;
      int unsigned                 count;
      bit                          err;
      len_result_type              r;
      if (start == '0) begin
         r.seq_length = '0;
         r.error_flag = 1'b1;
         return r;
      end
      v     = start;
      count = 1;
      err   = 1'b0;
      while (v != 64'd1) begin
         if (v < MEMO_ENTRIES && known_lengths[v[15:0]] != '0) begin
            count += 32'(known_lengths[v[15:0]]) - 1;
            if (count > 32'(clm_pkg::LEN_MAX)) begin
               err   = 1'b1;
               count = 32'(clm_pkg::LEN_MAX);
            end
            break;
         end
         if (v[0]) begin
            if (v > clm_pkg::ODD_LIMIT) begin
               err   = 1'b1;
               count = 0;
               break;
            end
            v = v * 3 + 1;
         end else begin
            v = v >> 1;
         end
         count++;
         if (count > 32'(clm_pkg::LEN_MAX)) begin
            err   = 1'b1;
            count = 32'(clm_pkg::LEN_MAX);
            break;
         end
      end
      if (!err && start < MEMO_ENTRIES)
         known_lengths[start[15:0]] = count[15:0];
      r.seq_length = count[15:0];
      r.error_flag = err;
      return r;
   endfunction

   function automatic logic [clm_pkg::VALUE_W-1:0] pick_start();
      int unsigned sel;
      sel = $urandom_range(0, 99);
      if (sel < 40)
         return 64'($urandom_range(1, MEMO_ENTRIES + 4000));
      else if (sel < 65)
         return {32'h0, 32'($urandom())};
      else if (sel < 85)
         return {32'($urandom()), 32'($urandom())};
      else if (sel < 95)
         return clm_pkg::ODD_LIMIT - 64'd64 + 64'($urandom_range(0, 128));
      else if (sel < 97)
         return 64'd1 << $urandom_range(0, 63);
      else if (sel < 98)
         return '0;
      else if (sel < 99)
         return '1;
      else
         return 64'd1;
   endfunction

   function automatic void add_corner(input logic [clm_pkg::VALUE_W-1:0] value, input bit known,
                                      input logic [clm_pkg::LEN_W-1:0] len, input logic err);
      start_row_type row;
      row.value             = value;
      row.known             = known;
      row.result.seq_length = len;
      row.result.error_flag = err;
      corner_starts.push_back(row);
   endfunction

   function automatic void note_failure(input string what, input len_result_type want,
                                        input len_result_type got);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
         $display("%0t mismatch (%s): expected length %0d err %0b, got length %0d err %0b",
                  $realtime, what, want.seq_length, want.error_flag,
                  got.seq_length, got.error_flag);
   endfunction

   function automatic void check_length(input len_result_type got);
      len_result_type want;
      if (pending_lengths.size() == 0) begin
         note_failure("result with nothing outstanding", '0, got);
         return;
      end
      want = pending_lengths.pop_front();
      if (got.seq_length !== want.seq_length)
         note_failure("seq_length", want, got);
      else if (got.error_flag !== want.error_flag)
         note_failure("error_flag", want, got);
   endfunction

   // The prediction is made on acceptance, so the local store is updated in the
   // same order as the block's own store.
   task automatic offer_start(input logic [clm_pkg::VALUE_W-1:0] value, input bit known,
                              input len_result_type known_result);
      len_result_type predicted;
      @(negedge clock);
      req_tdata  <= value;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      predicted = walk_length(value);
      pending_lengths.push_back(known ? known_result : predicted);
   endtask

   task automatic pause_sender(input int unsigned cycles);
      @(negedge clock);
      req_tvalid <= 1'b0;
      repeat (cycles - 1)
         @(negedge clock);
   endtask

   task automatic wait_for_drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_lengths.size() != 0)
         @(posedge clock);
   endtask

   // Request side and end of run.
   initial begin
      int unsigned idx;
      for (int i = 0; i < MEMO_ENTRIES; i++)
         known_lengths[i] = '0;

      add_corner(64'd0, 1'b1, 16'd0, 1'b1);
      add_corner(64'd1, 1'b1, 16'd1, 1'b0);
      add_corner(64'd2, 1'b1, 16'd2, 1'b0);
      add_corner(64'd4, 1'b1, 16'd3, 1'b0);
      add_corner(64'd3, 1'b0, '0, 1'b0);
      add_corner(64'd27, 1'b0, '0, 1'b0);
      add_corner(64'd27, 1'b0, '0, 1'b0);
      add_corner(64'd54, 1'b0, '0, 1'b0);
      add_corner(64'd97, 1'b0, '0, 1'b0);
      add_corner(64'(MEMO_ENTRIES - 1), 1'b0, '0, 1'b0);
      add_corner(64'(MEMO_ENTRIES), 1'b0, '0, 1'b0);
      add_corner(64'(MEMO_ENTRIES + 1), 1'b0, '0, 1'b0);
      add_corner(64'h8000_0000_0000_0000, 1'b1, 16'd64, 1'b0);
      add_corner('1, 1'b1, 16'd0, 1'b1);
      add_corner(clm_pkg::ODD_LIMIT + 64'd1, 1'b1, 16'd0, 1'b1);
      add_corner(clm_pkg::ODD_LIMIT, 1'b0, '0, 1'b0);
      // Odd and just inside the limit: the first step fits, a later one overflows.
      add_corner(clm_pkg::ODD_LIMIT - 64'd1, 1'b0, '0, 1'b0);
      add_corner(64'hAAAA_AAAA_AAAA_AAAA, 1'b0, '0, 1'b0);
      add_corner(64'h0000_0000_FFFF_FFFF, 1'b0, '0, 1'b0);
      add_corner(64'd1, 1'b1, 16'd1, 1'b0);
      add_corner(64'd0, 1'b1, 16'd0, 1'b1);

      repeat (9)
         @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (corner_starts[i]) begin
         offer_start(corner_starts[i].value, corner_starts[i].known, corner_starts[i].result);
         if ($urandom_range(0, 3) == 0)
            pause_sender($urandom_range(1, 12));
      end
      wait_for_drain();

      for (idx = 0; idx < RANDOM_ITEMS; idx++) begin
         if (idx == RANDOM_ITEMS - QUIET_ITEMS)
            quiet_tail = 1'b1;
         if (idx == HOLD_AT_ITEM)
            long_hold_req = 1'b1;
         if (idx == DRAIN_AT_ITEM)
            wait_for_drain();
         offer_start(pick_start(), 1'b0, '0);
         if (!quiet_tail && $urandom_range(0, 7) == 0)
            pause_sender($urandom_range(1, 12));
      end

      wait_for_drain();
      repeat (TAIL_CYCLES)
         @(posedge clock);
      if (mismatch_count == 0 && pending_lengths.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   // Result side: random stalls, plus one long hold-off while requests keep coming.
   initial begin
      int unsigned stall_left;
      int unsigned hold_left;
      stall_left = 0;
      hold_left  = 0;
      while (reset !== 1'b0)
         @(posedge clock);
      forever begin
         @(negedge clock);
         if (long_hold_req) begin
            hold_left     = LONG_HOLD;
            long_hold_req = 1'b0;
         end
         if (hold_left != 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else begin
            if (stall_left == 0 && !quiet_tail && $urandom_range(0, 9) == 0)
               stall_left = $urandom_range(1, 12);
            if (stall_left != 0) begin
               rsp_tready <= 1'b0;
               stall_left--;
            end else begin
               rsp_tready <= 1'b1;
            end
         end
         @(posedge clock);
         if (rsp_tvalid && rsp_tready)
            check_length({rsp_tdata, rsp_tuser});
      end
   end

   // Allows for the store-clearing pass and for every item walking far.
   initial begin
      #(400_000_000);
      $display("CHECK FAILED");
      $finish;
   end

endmodule
